FILE: hw/rtl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants of the beast frame deframer: phase codes, kind
// codes, sync and type bytes, register map and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

   // framing bytes
   localparam logic [7:0] SYNC_BYTE   = 8'h1A;
   localparam logic [7:0] TYPE_MODEAC = 8'h31;
   localparam logic [7:0] TYPE_SHORT  = 8'h32;
   localparam logic [7:0] TYPE_LONG   = 8'h33;

   // number of timestamp bytes after the type byte
   localparam logic [3:0] STAMP_BYTES = 4'd6;

   // frame kind codes
   localparam logic [1:0] KIND_MODEAC = 2'd0;
   localparam logic [1:0] KIND_SHORT  = 2'd1;
   localparam logic [1:0] KIND_LONG   = 2'd2;

   // register map
   localparam int         CSR_ADDR_W       = 3;
   localparam logic       CSR_IDX_MODEAC   = 1'b0;

   // parser phase, one-hot
   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_TYPE    = 5'b00010,
      PH_STAMP   = 5'b00100,
      PH_LEVEL   = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   // one result word
   typedef struct packed {
      logic [1:0]  frame_kind;
      logic [7:0]  payload_byte;
      logic [3:0]  byte_index;
      logic        last_byte;
      logic [47:0] time_stamp;
      logic [7:0]  signal_level;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/bfd_parser.sv
// ----------------------------------------------------------------------------
// bfd_parser
// Frame state machine: sync hunt, type decode, timestamp and level capture,
// escape removal and payload word generation, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_parser #(
   parameter int MODEAC_LEN = 2,
   parameter int SHORT_LEN  = 7,
   parameter int LONG_LEN   = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         rx_byte,
   input  wire logic               modeac_enable,
   output logic                    emit,
   output bfd_pkg::result_type     result
);

   bfd_pkg::phase_type phase_ff, phase_in;
   logic        skip_ff, skip_in;
   logic [1:0]  kind_ff, kind_in;
   logic [3:0]  count_ff, count_in;
   logic [47:0] stamp_ff, stamp_in;
   logic [7:0]  level_ff, level_in;
   logic        suppress_ff, suppress_in;

   logic [4:0]  frame_len;
   logic        is_last;
   logic        is_sync;

   // payload length of the held kind
   always_comb begin
      case (kind_ff)
         bfd_pkg::KIND_MODEAC: frame_len = 5'(MODEAC_LEN);
         bfd_pkg::KIND_SHORT:  frame_len = 5'(SHORT_LEN);
         default:              frame_len = 5'(LONG_LEN);
      endcase
   end

   assign is_last = ({1'b0, count_ff} + 5'd1) >= frame_len;
   assign is_sync = rx_byte == bfd_pkg::SYNC_BYTE;

   // result word for the current byte
   assign result.frame_kind   = kind_ff;
   assign result.payload_byte = rx_byte;
   assign result.byte_index   = count_ff;
   assign result.last_byte    = is_last;
   assign result.time_stamp   = stamp_ff;
   assign result.signal_level = level_ff;

   // next state
   always_comb begin
      phase_in    = phase_ff;
      skip_in     = skip_ff;
      kind_in     = kind_ff;
      count_in    = count_ff;
      stamp_in    = stamp_ff;
      level_in    = level_ff;
      suppress_in = suppress_ff;
      emit        = 1'b0;
      if (skip_ff) begin
         // byte after an escape is dropped
         skip_in = 1'b0;
      end else begin
         unique case (phase_ff)
            bfd_pkg::PH_HUNT: begin
               if (is_sync) phase_in = bfd_pkg::PH_TYPE;
            end
            bfd_pkg::PH_TYPE: begin
               case (rx_byte) inside
                  bfd_pkg::SYNC_BYTE: phase_in = bfd_pkg::PH_TYPE;
                  bfd_pkg::TYPE_MODEAC, bfd_pkg::TYPE_SHORT, bfd_pkg::TYPE_LONG: begin
                     kind_in     = 2'(rx_byte - bfd_pkg::TYPE_MODEAC);
                     suppress_in = (kind_in == bfd_pkg::KIND_MODEAC) && !modeac_enable;
                     count_in    = 4'd0;
                     stamp_in    = 48'd0;
                     phase_in    = bfd_pkg::PH_STAMP;
                  end
                  default: phase_in = bfd_pkg::PH_HUNT;
               endcase
            end
            bfd_pkg::PH_STAMP: begin
               stamp_in = {stamp_ff[39:0], rx_byte};
               skip_in  = is_sync;
               count_in = count_ff + 4'd1;
               if (count_in >= bfd_pkg::STAMP_BYTES) begin
                  count_in = 4'd0;
                  phase_in = bfd_pkg::PH_LEVEL;
               end
            end
            bfd_pkg::PH_LEVEL: begin
               level_in = rx_byte;
               skip_in  = is_sync;
               count_in = 4'd0;
               phase_in = bfd_pkg::PH_PAYLOAD;
            end
            bfd_pkg::PH_PAYLOAD: begin
               skip_in = is_sync;
               emit    = !suppress_ff;
               if (is_last) begin
                  count_in = 4'd0;
                  phase_in = bfd_pkg::PH_HUNT;
               end else begin
                  count_in = count_ff + 4'd1;
               end
            end
            default: phase_in = bfd_pkg::PH_HUNT;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= bfd_pkg::PH_HUNT;
         skip_ff     <= 1'b0;
         kind_ff     <= bfd_pkg::KIND_MODEAC;
         count_ff    <= 4'd0;
         stamp_ff    <= 48'd0;
         level_ff    <= 8'd0;
         suppress_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         skip_ff     <= skip_in;
         kind_ff     <= kind_in;
         count_ff    <= count_in;
         stamp_ff    <= stamp_in;
         level_ff    <= level_in;
         suppress_ff <= suppress_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/beast_frame_deframer_core.sv
// A byte taken at the req port goes through the input register, then the parser
// logic into the result register, before its payload word shows at the rsp port.
// Throughput: one byte per clock; the input register keeps taking bytes while
// one result waits, and stalls only when both registers are held.
// Reset: synchronous; the parser returns to sync hunt, modeac_enable clears.
// ----------------------------------------------------------------------------
// beast_frame_deframer_core
// Byte stream deframer for beast binary frames with an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module beast_frame_deframer_core #(
   parameter int MODEAC_LEN = 2,
   parameter int SHORT_LEN  = 7,
   parameter int LONG_LEN   = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // byte input
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [7:0]                    req_rx_byte,
   // payload words
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_frame_kind,
   output logic [7:0]                         rsp_payload_byte,
   output logic [3:0]                         rsp_byte_index,
   output logic                               rsp_last_byte,
   output logic [47:0]                        rsp_time_stamp,
   output logic [7:0]                         rsp_signal_level,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [bfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff, out_valid_in;
   bfd_pkg::result_type out_word_ff;
   logic                modeac_ff;

   logic                advance;
   logic                emit;
   bfd_pkg::result_type word;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == bfd_pkg::CSR_IDX_MODEAC) ? {31'd0, modeac_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         modeac_ff <= 1'b0;
      end else if (psel && penable && pwrite && (paddr[2] == bfd_pkg::CSR_IDX_MODEAC)) begin
         modeac_ff <= pwdata[0];
      end
   end

   // pipeline control
   assign advance     = !out_valid_ff || !rsp_stall;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? (in_valid_ff && emit) : out_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // frame parser
   bfd_parser #(
      .MODEAC_LEN (MODEAC_LEN),
      .SHORT_LEN  (SHORT_LEN),
      .LONG_LEN   (LONG_LEN)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (in_valid_ff && advance),
      .rx_byte       (in_byte_ff),
      .modeac_enable (modeac_ff),
      .emit          (emit),
      .result        (word)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff && emit) begin
         out_word_ff <= word;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_kind   = out_word_ff.frame_kind;
   assign rsp_payload_byte = out_word_ff.payload_byte;
   assign rsp_byte_index   = out_word_ff.byte_index;
   assign rsp_last_byte    = out_word_ff.last_byte;
   assign rsp_time_stamp   = out_word_ff.time_stamp;
   assign rsp_signal_level = out_word_ff.signal_level;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the beast frame deframer core. A byte driver feeds
// the stream from a queue, an in-bench deframer works out the payload words
// each byte should cause, and a word monitor checks every word field by field.
// The mode a/c enable register is toggled between phases, once in mid-frame,
// while both sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bfd_pkg::*;

   localparam int MODEAC_LEN = 2;
   localparam int SHORT_LEN  = 7;
   localparam int LONG_LEN   = 14;

   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_BYTES  = 120;
   localparam int STALL_LIMIT  = 4000;
   localparam int SETTLE_WAIT  = 4;

   localparam logic [CSR_ADDR_W-1:0] MODEAC_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_MODEAC));

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #2 clock = ~clock;

   // block inputs, known from time zero
   logic                  req_valid   = 1'b0;
   logic [7:0]            req_rx_byte = 8'h00;
   logic                  rsp_stall   = 1'b0;
   logic                  psel        = 1'b0;
   logic                  penable     = 1'b0;
   logic                  pwrite      = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr       = '0;
   logic [31:0]           pwdata      = '0;

   // block outputs
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_frame_kind;
   logic [7:0]  rsp_payload_byte;
   logic [3:0]  rsp_byte_index;
   logic        rsp_last_byte;
   logic [47:0] rsp_time_stamp;
   logic [7:0]  rsp_signal_level;
   logic [31:0] prdata;
   logic        pready;

   beast_frame_deframer_core #(
      .MODEAC_LEN(MODEAC_LEN),
      .SHORT_LEN (SHORT_LEN),
      .LONG_LEN  (LONG_LEN)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_time_stamp  (rsp_time_stamp),
      .rsp_signal_level(rsp_signal_level),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // stream waiting to be sent and payload words still owed by the block
   logic [7:0] byte_queue[$];
   logic [7:0] frame_bytes[$];
   result_type payload_expect[$];

   bit send_calm = 1'b1;
   bit recv_calm = 1'b1;
   int gap_left   = 0;
   int stall_left = 0;

   int error_count   = 0;
   int bytes_queued  = 0;
   int bytes_sent    = 0;
   int words_checked = 0;
   int csr_writes    = 0;
   int kind_built[3] = '{0, 0, 0};

   // deframer state, mirrored from the block
   bit          modeac_on     = 1'b0;
   phase_type   parse_phase   = PH_HUNT;
   bit          skip_pending  = 1'b0;
   logic [1:0]  held_kind     = KIND_MODEAC;
   logic [3:0]  field_count   = 4'd0;
   logic [47:0] held_stamp    = '0;
   logic [7:0]  held_level    = 8'h00;
   bit          drop_frame    = 1'b0;

   function automatic int payload_len(input logic [1:0] kind);
      if (kind == KIND_MODEAC) return MODEAC_LEN;
      if (kind == KIND_SHORT) return SHORT_LEN;
      return LONG_LEN;
   endfunction

   // advance the deframer by one stream byte; returns 1 when a word is due
   function automatic bit deframe_byte(input logic [7:0] rx, output result_type word);
      bit emit;
      bit is_last;
      emit = 1'b0;
      word = '0;
      if (skip_pending) begin
         skip_pending = 1'b0;
         return 1'b0;
      end
      case (parse_phase)
         PH_HUNT: begin
            if (rx == SYNC_BYTE) parse_phase = PH_TYPE;
         end
         PH_TYPE: begin
            if (rx == SYNC_BYTE) begin
               parse_phase = PH_TYPE;
            end else if (rx == TYPE_MODEAC || rx == TYPE_SHORT || rx == TYPE_LONG) begin
               held_kind = (rx == TYPE_MODEAC) ? KIND_MODEAC :
                           (rx == TYPE_SHORT)  ? KIND_SHORT  : KIND_LONG;
               drop_frame  = (held_kind == KIND_MODEAC) && !modeac_on;
               field_count = 4'd0;
               held_stamp  = '0;
               parse_phase = PH_STAMP;
            end else begin
               parse_phase = PH_HUNT;
            end
         end
         PH_STAMP: begin
            held_stamp = {held_stamp[39:0], rx};
            if (rx == SYNC_BYTE) skip_pending = 1'b1;
            field_count = field_count + 4'd1;
            if (field_count >= STAMP_BYTES) begin
               field_count = 4'd0;
               parse_phase = PH_LEVEL;
            end
         end
         PH_LEVEL: begin
            held_level = rx;
            if (rx == SYNC_BYTE) skip_pending = 1'b1;
            field_count = 4'd0;
            parse_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            is_last = (int'(field_count) + 1 >= payload_len(held_kind));
            if (rx == SYNC_BYTE) skip_pending = 1'b1;
            if (!drop_frame) begin
               word.frame_kind   = held_kind;
               word.payload_byte = rx;
               word.byte_index   = field_count;
               word.last_byte    = is_last;
               word.time_stamp   = held_stamp;
               word.signal_level = held_level;
               emit = 1'b1;
            end
            if (is_last) begin
               field_count = 4'd0;
               parse_phase = PH_HUNT;
            end else begin
               field_count = field_count + 4'd1;
            end
         end
         default: begin
            parse_phase = PH_HUNT;
         end
      endcase
      return emit;
   endfunction

   function automatic int draw_wait(input bit calm);
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic void check_field(input string name, input logic [47:0] want,
                                       input logic [47:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         error_count++;
      end
   endfunction

   // byte driver: one byte per handshake, random gap after each
   always @(posedge clock) begin : byte_driver
      bit         next_valid;
      result_type word;
      if (!reset) begin
         next_valid = req_valid;
         if (req_valid && !req_stall) begin
            if (deframe_byte(req_rx_byte, word)) payload_expect.push_back(word);
            bytes_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (byte_queue.size() > 0) begin
               req_rx_byte <= byte_queue.pop_front();
               next_valid = 1'b1;
               gap_left = draw_wait(send_calm);
            end
         end
         req_valid <= next_valid;
      end
   end

   // word monitor: checks against the oldest owed word, random stall per word
   always @(posedge clock) begin : word_monitor
      result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (payload_expect.size() == 0) begin
               $error("unexpected payload word: byte 'h%0h index %0d",
                      rsp_payload_byte, rsp_byte_index);
               error_count++;
            end else begin
               want = payload_expect.pop_front();
               check_field("frame_kind", want.frame_kind, rsp_frame_kind);
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("byte_index", want.byte_index, rsp_byte_index);
               check_field("last_byte", want.last_byte, rsp_last_byte);
               check_field("time_stamp", want.time_stamp, rsp_time_stamp);
               check_field("signal_level", want.signal_level, rsp_signal_level);
            end
            words_checked++;
            stall_left = draw_wait(recv_calm);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 15))
         0, 1: return SYNC_BYTE;
         2:    return 8'h00;
         3:    return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void push_one(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endfunction

   // in-frame byte: a sync value drags a discarded byte behind it
   function automatic void add_in_frame(input logic [7:0] b);
      frame_bytes.push_back(b);
      if (b == SYNC_BYTE) frame_bytes.push_back($urandom_range(0, 1) ? SYNC_BYTE : 8'($urandom));
   endfunction

   function automatic void build_frame(input logic [1:0] kind);
      int stamp_mode;
      stamp_mode = $urandom_range(0, 5);
      frame_bytes.delete();
      frame_bytes.push_back(SYNC_BYTE);
      if ($urandom_range(0, 7) == 0) frame_bytes.push_back(SYNC_BYTE);
      frame_bytes.push_back(kind == KIND_MODEAC ? TYPE_MODEAC :
                            kind == KIND_SHORT  ? TYPE_SHORT  : TYPE_LONG);
      for (int i = 0; i < STAMP_BYTES; i++)
         add_in_frame(stamp_mode == 0 ? 8'h00 : stamp_mode == 1 ? 8'hFF : rand_byte());
      add_in_frame(rand_byte());
      for (int i = 0; i < payload_len(kind); i++) add_in_frame(rand_byte());
      kind_built[kind]++;
   endfunction

   function automatic void push_range(input int first, input int count);
      for (int i = first; i < first + count; i++) push_one(frame_bytes[i]);
   endfunction

   // wait until every queued byte is sent and every owed word has come
   task automatic wait_idle();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_valid || payload_expect.size() != 0);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == MODEAC_ADDR) modeac_on = data[0];
      csr_writes++;
   endtask

   // stimulus
   initial begin : stimulus
      logic [7:0] opening[16];
      logic [7:0] bad_type;
      int         phase_start;
      int         pick;
      logic [1:0] kind;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // double sync, escapes in stamp and payload, discard after frame, bad type
      opening = '{SYNC_BYTE, SYNC_BYTE, TYPE_MODEAC,
                  8'h00, SYNC_BYTE, 8'h5A, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'h00, SYNC_BYTE, SYNC_BYTE,
                  SYNC_BYTE, 8'h30};
      foreach (opening[i]) push_one(opening[i]);
      wait_idle();

      // emitted mode a/c frame with extreme stamp, level and payload
      csr_write(MODEAC_ADDR, 32'd1);
      push_one(SYNC_BYTE);
      push_one(TYPE_MODEAC);
      repeat (STAMP_BYTES) push_one(8'hFF);
      push_one(8'h00);
      push_one(8'hFF);
      push_one(8'h00);
      wait_idle();

      // register change in mid-frame only takes effect at the next type byte
      build_frame(KIND_MODEAC);
      push_range(0, 5);
      wait_idle();
      csr_write(MODEAC_ADDR, 32'd0);
      push_range(5, frame_bytes.size() - 5);
      build_frame(KIND_MODEAC);
      push_range(0, frame_bytes.size());
      build_frame(KIND_SHORT);
      push_range(0, frame_bytes.size());
      build_frame(KIND_LONG);
      push_range(0, frame_bytes.size());

      // random phases, mostly well-formed frames
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         csr_write(MODEAC_ADDR, {31'd0, 1'(p % 2 == 0)});
         send_calm = (p == 0) || ($urandom_range(0, 3) == 0);
         recv_calm = (p == 0) || ($urandom_range(0, 3) == 0);
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < PHASE_BYTES) begin
            pick = $urandom_range(0, 19);
            kind = 2'($urandom_range(0, 2));
            if (pick < 14) begin
               build_frame(kind);
               push_range(0, frame_bytes.size());
            end else if (pick < 16) begin
               repeat ($urandom_range(1, 4)) push_one(8'($urandom));
            end else if (pick < 18) begin
               do bad_type = 8'($urandom);
               while (bad_type == SYNC_BYTE || bad_type == TYPE_MODEAC ||
                      bad_type == TYPE_SHORT || bad_type == TYPE_LONG);
               push_one(SYNC_BYTE);
               push_one(bad_type);
            end else begin
               build_frame(kind);
               push_range(0, $urandom_range(2, frame_bytes.size() - 1));
            end
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (payload_expect.size() != 0) begin
         $error("%0d payload words never arrived", payload_expect.size());
         error_count++;
      end

      $display("covered %0d stream bytes and %0d payload words over %0d register writes",
               bytes_sent, words_checked, csr_writes);
      $display("frames built: %0d mode a/c, %0d short, %0d long",
               kind_built[KIND_MODEAC], kind_built[KIND_SHORT], kind_built[KIND_LONG]);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bfd_pkg.sv
hw/rtl/bfd_parser.sv
hw/rtl/beast_frame_deframer_core.sv
tb/tb_top.sv
